// File: hw/rtl/ksp_pkg.sv
// Shared types and constants for the keyed stack with positional insert.
`timescale 1ns / 1ps

package ksp_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 64;
    localparam int POS_W = 5;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_INSERT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Scan set-up flavours: read from the top down, close a gap, open a gap
    typedef enum logic [1:0] {
        SU_TOP,
        SU_REMOVE,
        SU_INSERT
    } t_setup;

    // Change applied to the stack when the result is registered
    typedef enum logic [2:0] {
        CM_NONE,
        CM_PUSH,
        CM_POP,
        CM_REMOVE,
        CM_INSERT
    } t_commit;

    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [POS_W-1:0]  position;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [KEY_W-1:0]  popped_key;
        logic [CNT_W-1:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic     load;
        logic     setup_en;
        t_setup   setup;
        logic     scan;
        logic     res_load;
        t_commit  commit;
        t_status  res_status;
    } t_cmd;

    typedef struct packed {
        t_op   op;
        logic  full;
        logic  empty;
        logic  more;
        logic  pend;
        logic  hit;
    } t_stat;

endpackage

// File: hw/rtl/ksp_dpath.sv
// Datapath: entry memory, count, scan pointer and result register.
`timescale 1ns / 1ps

module ksp_dpath import ksp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_in_data,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_out  o_out_data
);

    logic [KEY_W-1:0] mem [DEPTH];

    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [POS_W-1:0] r_pos;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_lim;
    logic             r_more;
    logic             r_pend;
    logic [IDX_W-1:0] r_pidx;
    logic [KEY_W-1:0] r_rdata;
    logic             r_rd_up;
    logic             r_wr_up;
    logic             r_wr_dn;
    logic [IDX_W-1:0] r_ins_idx;
    t_out             r_out;

    logic [IDX_W-1:0] top_idx;
    logic [IDX_W-1:0] ins_idx;
    logic             pos_past;
    logic             rd_en;
    logic             sh_wr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic [CNT_W-1:0] n_count;

    assign top_idx  = IDX_W'(r_count - CNT_W'(1));
    assign pos_past = CMP_W'(r_pos) >= CMP_W'(r_count);
    // Depth past the bottom lands at index zero
    assign ins_idx  = pos_past ? '0 : IDX_W'(r_count - CNT_W'(r_pos));

    assign rd_en = i_cmd.scan && r_more;
    assign sh_wr = i_cmd.scan && r_pend && (r_wr_up || r_wr_dn);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_rdata;
        if (sh_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_wr_up ? (r_pidx + IDX_W'(1)) : (r_pidx - IDX_W'(1));
        end else if (i_cmd.res_load && i_cmd.commit == CM_PUSH) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(r_count);
            wr_data = r_key;
        end else if (i_cmd.res_load && i_cmd.commit == CM_INSERT) begin
            wr_en   = 1'b1;
            wr_addr = r_ins_idx;
            wr_data = r_key;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.res_load) begin
            unique case (i_cmd.commit)
                CM_PUSH, CM_INSERT: n_count = r_count + CNT_W'(1);
                CM_POP, CM_REMOVE:  n_count = r_count - CNT_W'(1);
                default:            n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_more  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.setup_en) begin
                r_pend <= 1'b0;
                unique case (i_cmd.setup)
                    SU_TOP:    r_more <= (r_count != '0);
                    SU_REMOVE: r_more <= (CNT_W'(r_pidx) + CNT_W'(1)) != r_count;
                    SU_INSERT: r_more <= CNT_W'(ins_idx) != r_count;
                    default:   r_more <= 1'b0;
                endcase
            end else if (i_cmd.scan) begin
                r_pend <= r_more;
                if (r_more && r_ptr == r_lim) begin
                    r_more <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_data.op;
            r_key <= i_in_data.key;
            r_pos <= i_in_data.position;
        end
        if (i_cmd.setup_en) begin
            unique case (i_cmd.setup)
                SU_TOP: begin
                    r_ptr   <= top_idx;
                    r_lim   <= '0;
                    r_rd_up <= 1'b0;
                    r_wr_up <= 1'b0;
                    r_wr_dn <= 1'b0;
                end
                SU_REMOVE: begin
                    r_ptr   <= r_pidx + IDX_W'(1);
                    r_lim   <= top_idx;
                    r_rd_up <= 1'b1;
                    r_wr_up <= 1'b0;
                    r_wr_dn <= 1'b1;
                end
                SU_INSERT: begin
                    r_ptr     <= top_idx;
                    r_lim     <= ins_idx;
                    r_rd_up   <= 1'b0;
                    r_wr_up   <= 1'b1;
                    r_wr_dn   <= 1'b0;
                    r_ins_idx <= ins_idx;
                end
                default: begin
                    r_ptr   <= '0;
                    r_lim   <= '0;
                    r_rd_up <= 1'b0;
                    r_wr_up <= 1'b0;
                    r_wr_dn <= 1'b0;
                end
            endcase
        end else if (rd_en) begin
            r_pidx <= r_ptr;
            if (r_ptr != r_lim) begin
                r_ptr <= r_rd_up ? (r_ptr + IDX_W'(1)) : (r_ptr - IDX_W'(1));
            end
        end
        if (i_cmd.res_load) begin
            r_out.status      <= i_cmd.res_status;
            r_out.popped_key  <= (i_cmd.commit == CM_POP) ? r_rdata : '0;
            r_out.entry_count <= n_count;
        end
    end

    assign o_stat.op    = r_op;
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.more  = r_more;
    assign o_stat.pend  = r_pend;
    assign o_stat.hit   = r_pend && (r_rdata == r_key);
    assign o_out_data   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (wr_addr != r_ptr))
        else $error("shift writes the entry being read");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_load && i_cmd.commit == CM_PUSH)
            |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not grow the stack");

endmodule

// File: hw/rtl/ksp_ctrl.sv
// Controller: sequences dispatch, search, shift and result for each operation.
`timescale 1ns / 1ps

module ksp_ctrl import ksp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  logic  i_out_stall,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_POPRD,
        S_SRCH,
        S_RSHIFT,
        S_ISHIFT,
        S_RES
    } t_state;

    t_state  r_state, n_state;
    t_status r_res_status, n_res_status;
    t_commit r_commit, n_commit;
    logic    r_out_vld;
    logic    out_free;

    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_commit     = r_commit;
        o_cmd        = '0;
        o_cmd.setup  = SU_TOP;
        o_cmd.commit = r_commit;
        o_cmd.res_status = r_res_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.op)
                    OP_PUSH: begin
                        n_state      = S_RES;
                        n_res_status = i_stat.full ? ST_FULL : ST_DONE;
                        n_commit     = i_stat.full ? CM_NONE : CM_PUSH;
                    end
                    OP_POP: begin
                        if (i_stat.empty) begin
                            n_state      = S_RES;
                            n_res_status = ST_EMPTY;
                            n_commit     = CM_NONE;
                        end else begin
                            o_cmd.setup_en = 1'b1;
                            o_cmd.setup    = SU_TOP;
                            n_state        = S_POPRD;
                        end
                    end
                    OP_REMOVE: begin
                        o_cmd.setup_en = 1'b1;
                        o_cmd.setup    = SU_TOP;
                        n_state        = S_SRCH;
                    end
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            n_state      = S_RES;
                            n_res_status = ST_FULL;
                            n_commit     = CM_NONE;
                        end else begin
                            o_cmd.setup_en = 1'b1;
                            o_cmd.setup    = SU_INSERT;
                            n_state        = S_ISHIFT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_POPRD: begin
                // one read of the top entry, then hold it for the result
                o_cmd.scan   = 1'b1;
                n_state      = S_RES;
                n_res_status = ST_DONE;
                n_commit     = CM_POP;
            end
            S_SRCH: begin
                priority if (i_stat.hit) begin
                    o_cmd.setup_en = 1'b1;
                    o_cmd.setup    = SU_REMOVE;
                    n_state        = S_RSHIFT;
                end else if (!i_stat.more && !i_stat.pend) begin
                    n_state      = S_RES;
                    n_res_status = ST_NOTFOUND;
                    n_commit     = CM_NONE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_RSHIFT, S_ISHIFT: begin
                if (!i_stat.more && !i_stat.pend) begin
                    n_state      = S_RES;
                    n_res_status = ST_DONE;
                    n_commit     = (r_state == S_RSHIFT) ? CM_REMOVE : CM_INSERT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_RES: begin
                // hold until the output register can take the transfer
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_status <= ST_DONE;
            r_commit     <= CM_NONE;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
            r_commit     <= n_commit;
            r_out_vld    <= (r_out_vld && i_out_stall) || o_cmd.res_load;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

    a_res_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> !(r_out_vld && i_out_stall))
        else $error("result overwrites a waiting transfer");

    a_scan_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.scan && o_cmd.setup_en))
        else $error("scan and set-up in one cycle");

    a_load_then_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DISP))
        else $error("accepted item not dispatched");

endmodule

// File: hw/rtl/keyed_stack_with_positional_insert.sv
// Top level of the keyed stack with positional insert.
//
//  channel | direction | handshake                 | payload
//  in      | to block  | i_in_valid / o_in_stall   | i_in_data  (op, key, position)
//  out     | from block| o_out_valid / i_out_stall | o_out_data (status, popped_key, entry_count)
//
// One item at a time. Push, refused insert and pop on empty go from dispatch straight to the result.
// Remove reads one entry a cycle from the top down to the match, then closes the gap
// from the match up to the top; with no match it reads every entry down to the bottom.
// Insert opens a gap from the top down to its depth.
// The entry memory has a single read port.
// Reset clears the count and control only; entries are written before they are read.
// A stalled result holds in the output register while the next item is taken in.
`timescale 1ns / 1ps

module keyed_stack_with_positional_insert import ksp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    ksp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ksp_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

// File: sim/tb_keyed_stack_with_positional_insert.sv
// Testbench for the keyed stack: directed and random operations checked against a predicted stack.
`timescale 1ns / 1ps

module tb_keyed_stack_with_positional_insert;
    import ksp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_data = '0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    // Predicted stack contents, bottom at index 0
    logic [KEY_W-1:0] stack_mem [DEPTH];
    int               stack_count = 0;
    t_out             stack_outcome_q [$];
    logic [KEY_W-1:0] key_pool [6];

    int error_count = 0;
    bit idle_en = 1'b1;
    bit stall_en = 1'b1;
    int stall_left = 0;

    always #10 i_clk = ~i_clk;

    keyed_stack_with_positional_insert dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    function automatic t_out stack_apply(input t_in item);
        t_out res;
        int   idx;
        bit   found;
        res.status = ST_DONE;
        res.popped_key = '0;
        case (item.op)
            OP_PUSH: begin
                if (stack_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    stack_mem[stack_count] = item.key;
                    stack_count++;
                end
            end
            OP_POP: begin
                if (stack_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    stack_count--;
                    res.popped_key = stack_mem[stack_count];
                end
            end
            OP_REMOVE: begin
                found = 1'b0;
                // search from the top down, close the gap above the match
                for (int i = stack_count; i > 0 && !found; i--) begin
                    if (stack_mem[i-1] == item.key) begin
                        for (int j = i - 1; j + 1 < stack_count; j++)
                            stack_mem[j] = stack_mem[j+1];
                        stack_count--;
                        found = 1'b1;
                    end
                end
                if (!found)
                    res.status = ST_NOTFOUND;
            end
            default: begin
                if (stack_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    idx = (item.position >= stack_count) ? 0 : stack_count - item.position;
                    for (int i = stack_count; i > idx; i--)
                        stack_mem[i] = stack_mem[i-1];
                    stack_mem[idx] = item.key;
                    stack_count++;
                end
            end
        endcase
        res.entry_count = CNT_W'(stack_count);
        return res;
    endfunction

    function automatic t_in make_op(input t_op op, input logic [KEY_W-1:0] key,
                                    input logic [POS_W-1:0] pos);
        t_in item;
        item.op = op;
        item.key = key;
        item.position = pos;
        return item;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input bit from_stack);
        int roll;
        roll = $urandom_range(0, 99);
        if (from_stack && stack_count > 0 && roll < 70)
            return stack_mem[$urandom_range(0, stack_count - 1)];
        if (roll < 80)
            return key_pool[$urandom_range(0, 5)];
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Send one operation; predict its outcome at the transfer
    task automatic send_op(input t_in item);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge i_clk); while (in_stall);
        stack_outcome_q.push_back(stack_apply(item));
    endtask

    // Receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (!stall_en) begin
            stall_left = 0;
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (stack_outcome_q.size() == 0) begin
                report_mismatch("result transfer with no operation outstanding");
            end else begin
                want = stack_outcome_q.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              out_data.status, want.status));
                if (out_data.popped_key !== want.popped_key)
                    report_mismatch($sformatf("popped_key got %h want %h",
                                              out_data.popped_key, want.popped_key));
                if (out_data.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              out_data.entry_count, want.entry_count));
            end
        end
    end

    task automatic test_empty_stack();
        send_op(make_op(OP_POP, {$urandom, $urandom}, 5'd0));
        send_op(make_op(OP_REMOVE, '0, 5'd31));
    endtask

    task automatic test_push_pop_insert();
        send_op(make_op(OP_PUSH, '0, 5'd0));
        send_op(make_op(OP_PUSH, '1, 5'd31));
        send_op(make_op(OP_INSERT, key_pool[2], 5'd0));
        send_op(make_op(OP_INSERT, key_pool[3], 5'd31));
        send_op(make_op(OP_INSERT, key_pool[4], 5'd16));
        send_op(make_op(OP_INSERT, key_pool[2], 5'd2));
        // duplicate key: the upper copy goes first
        send_op(make_op(OP_REMOVE, key_pool[2], 5'd0));
        send_op(make_op(OP_REMOVE, key_pool[5], 5'd0));
        send_op(make_op(OP_POP, '0, 5'd0));
        send_op(make_op(OP_POP, '0, 5'd0));
    endtask

    task automatic test_full_stack();
        while (stack_count < DEPTH)
            send_op(make_op(OP_PUSH, {$urandom, $urandom}, POS_W'($urandom_range(0, 31))));
        send_op(make_op(OP_PUSH, '1, 5'd0));
        send_op(make_op(OP_INSERT, '0, 5'd0));
        // bottom entry: longest walk for remove
        send_op(make_op(OP_REMOVE, stack_mem[0], 5'd0));
        send_op(make_op(OP_INSERT, '1, 5'd15));
    endtask

    task automatic test_random_traffic(input int n_items, input bit bursts);
        t_in item;
        int  roll;
        int  mode;
        mode = 2;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) begin
                mode = $urandom_range(0, 2);
                if (bursts) begin
                    idle_en = ($urandom_range(0, 3) != 0);
                    stall_en = ($urandom_range(0, 3) != 0);
                end
            end
            roll = $urandom_range(0, 99);
            // grow, shrink or balanced mix so the count sweeps empty to full
            if (mode == 0)
                roll = (roll < 40) ? 0 : (roll < 75) ? 3 : (roll < 88) ? 2 : 1;
            else if (mode == 1)
                roll = (roll < 15) ? 0 : (roll < 25) ? 3 : (roll < 60) ? 2 : 1;
            else
                roll = roll / 25;
            case (roll)
                0:       item.op = OP_PUSH;
                1:       item.op = OP_POP;
                2:       item.op = OP_REMOVE;
                default: item.op = OP_INSERT;
            endcase
            item.key = pick_key(item.op == OP_REMOVE);
            if ($urandom_range(0, 1) == 0)
                item.position = POS_W'($urandom_range(0, stack_count));
            else
                item.position = POS_W'($urandom_range(0, 31));
            send_op(item);
        end
    endtask

    task automatic test_unbroken_traffic(input int n_items);
        idle_en = 1'b0;
        stall_en = 1'b0;
        test_random_traffic(n_items, 1'b0);
    endtask

    initial begin
        int waited;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = {$urandom, $urandom};
        key_pool[3] = {$urandom, $urandom};
        key_pool[4] = 64'h8000_0000_0000_0000;
        key_pool[5] = 64'h0000_0000_0000_0001;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_stack();
        test_push_pop_insert();
        test_full_stack();
        test_random_traffic(1500, 1'b1);
        test_unbroken_traffic(250);

        @(negedge i_clk);
        in_valid <= 1'b0;
        waited = 0;
        while (stack_outcome_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (stack_outcome_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", stack_outcome_q.size()));
        if (error_count == 0)
            $display("tb_keyed_stack_with_positional_insert: done, clean");
        else
            $display("tb_keyed_stack_with_positional_insert: done, errors");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("tb_keyed_stack_with_positional_insert: done, errors");
        $finish;
    end

endmodule
